// ----- design/cobsd_pkg.sv -----
package cobsd_pkg;

	localparam int FRAME_BYTES_DEF = 64;
	localparam logic [7:0] GROUP_FULL_CODE = 8'hFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_RD_LEN,
		ST_RD_ACT,
		ST_CAP_ACT,
		ST_RD_BODY,
		ST_LOAD
	} ctrl_state_t;

	typedef enum logic [1:0] {
		RD_LEN,
		RD_ACT,
		RD_BODY
	} rd_sel_t;

	typedef struct packed {
		logic    push;
		logic    append_zero;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_len;
		logic    cap_act;
		logic    load_out;
		logic    body_next;
		logic    clear_frame;
	} dp_cmd_t;

	typedef struct packed {
		logic two_appends;
		logic byte_zero;
		logic out_busy;
		logic last_item;
	} dp_status_t;

endpackage

// ----- design/cobsd_ifs.sv -----
interface cobsd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface cobsd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_length;
	logic [7:0] msg_action;
	logic [7:0] body_byte;
	logic [5:0] body_index;
	logic       body_valid;
	logic       overflowed;
	logic       last;

	modport source (
		output valid, output msg_length, output msg_action, output body_byte,
		output body_index, output body_valid, output overflowed, output last,
		input ready
	);
	modport sink (
		input valid, input msg_length, input msg_action, input body_byte,
		input body_index, input body_valid, input overflowed, input last,
		output ready
	);
endinterface

// ----- design/cobsd_ctrl.sv -----
module cobsd_ctrl
	import cobsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t sts,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.byte_zero) begin
						state_nx = ST_RD_LEN;
					end else begin
						cmd.push = 1'b1;
						if (sts.two_appends) begin
							state_nx = ST_ZERO;
						end
					end
				end
			end
			ST_ZERO: begin
				cmd.append_zero = 1'b1;
				state_nx        = ST_IDLE;
			end
			ST_RD_LEN: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_LEN;
				state_nx   = ST_RD_ACT;
			end
			ST_RD_ACT: begin
				cmd.cap_len = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_ACT;
				state_nx    = ST_CAP_ACT;
			end
			ST_CAP_ACT: begin
				cmd.cap_act = 1'b1;
				state_nx    = ST_RD_BODY;
			end
			ST_RD_BODY: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_BODY;
				state_nx   = ST_LOAD;
			end
			ST_LOAD: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					if (sts.last_item) begin
						cmd.clear_frame = 1'b1;
						state_nx        = ST_IDLE;
					end else begin
						cmd.body_next = 1'b1;
						state_nx      = ST_RD_BODY;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/cobsd_dp.sv -----
module cobsd_dp
	import cobsd_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  dp_cmd_t    cmd,
	output dp_status_t sts,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] msg_length,
	output logic [7:0] msg_action,
	output logic [7:0] body_byte,
	output logic [5:0] body_index,
	output logic       body_valid,
	output logic       overflowed,
	output logic       last
);

	localparam int AW = $clog2(FRAME_BYTES);
	localparam int CW = AW + 1;

	logic [7:0]    mem [FRAME_BYTES];
	logic [CW-1:0] count_q;
	logic [7:0]    group_left_q;
	logic          group_full_q;
	logic          overflow_q;

	logic [7:0]    rdata_s1;
	logic          rd_ok_s1;
	logic [7:0]    len_q;
	logic [7:0]    act_q;
	logic [AW-1:0] k_q;

	logic          out_valid_q;
	logic [7:0]    out_len_q;
	logic [7:0]    out_act_q;
	logic [7:0]    out_byte_q;
	logic [5:0]    out_index_q;
	logic          out_bvalid_q;
	logic          out_ovf_q;
	logic          out_last_q;

	logic          gl_zero;
	logic [7:0]    gl_nx;
	logic          full_nx;
	logic          zero_after;
	logic          wr_req;
	logic [7:0]    wr_data;
	logic          room;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_val;
	logic          have_body;
	logic [7:0]    n_raw;
	logic [7:0]    n_sat;
	logic [AW-1:0] n_items;
	logic          last_w;

	// Stuffing decode for the byte offered at the input.
	always_comb begin
		gl_zero    = (group_left_q == 8'd0);
		gl_nx      = gl_zero ? (rx_byte - 8'd1) : (group_left_q - 8'd1);
		full_nx    = gl_zero ? (rx_byte == GROUP_FULL_CODE) : group_full_q;
		zero_after = (gl_nx == 8'd0) && !full_nx;
		wr_req     = (cmd.push && (!gl_zero || zero_after)) || cmd.append_zero;
		wr_data    = (cmd.push && !gl_zero) ? rx_byte : 8'd0;
		room       = (count_q < CW'(FRAME_BYTES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			group_left_q <= '0;
			group_full_q <= 1'b0;
			overflow_q   <= 1'b0;
		end else if (cmd.clear_frame) begin
			count_q      <= '0;
			group_left_q <= '0;
			group_full_q <= 1'b0;
			overflow_q   <= 1'b0;
		end else begin
			if (cmd.push) begin
				group_left_q <= gl_nx;
				group_full_q <= full_nx;
			end
			if (wr_req) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_req && room) begin
			mem[count_q[AW-1:0]] <= wr_data;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_LEN:  rd_addr = AW'(0);
			RD_ACT:  rd_addr = AW'(1);
			RD_BODY: rd_addr = k_q + AW'(2);
			default: rd_addr = AW'(0);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_addr];
			rd_ok_s1 <= ({1'b0, rd_addr} < count_q);
		end
	end

	assign rd_val = rd_ok_s1 ? rdata_s1 : 8'd0;

	always_ff @(posedge clk) begin
		if (cmd.cap_len) begin
			len_q <= rd_val;
		end
		if (cmd.cap_act) begin
			act_q <= rd_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.cap_act) begin
			k_q <= '0;
		end else if (cmd.body_next) begin
			k_q <= k_q + AW'(1);
		end
	end

	// Number of results for this message, capped at the body positions of the store.
	always_comb begin
		have_body = (len_q > 8'd2);
		n_raw     = have_body ? (len_q - 8'd2) : 8'd1;
		n_sat     = (n_raw > 8'(FRAME_BYTES - 2)) ? 8'(FRAME_BYTES - 2) : n_raw;
		n_items   = AW'(n_sat);
		last_w    = (({1'b0, k_q} + CW'(1)) == {1'b0, n_items});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_len_q    <= len_q;
			out_act_q    <= act_q;
			out_byte_q   <= have_body ? rd_val : 8'd0;
			out_index_q  <= have_body ? 6'(k_q) : 6'd0;
			out_bvalid_q <= have_body;
			out_ovf_q    <= overflow_q;
			out_last_q   <= last_w;
		end
	end

	always_comb begin
		sts.two_appends = !gl_zero && zero_after;
		sts.byte_zero   = (rx_byte == 8'd0);
		sts.out_busy    = out_valid_q && !out_ready;
		sts.last_item   = last_w;
	end

	assign out_valid  = out_valid_q;
	assign msg_length = out_len_q;
	assign msg_action = out_act_q;
	assign body_byte  = out_byte_q;
	assign body_index = out_index_q;
	assign body_valid = out_bvalid_q;
	assign overflowed = out_ovf_q;
	assign last       = out_last_q;

endmodule

// ----- design/cobs_message_deframer.sv -----
// COBS message deframer. Stuffed bytes enter on rx and are decoded into a
// frame store of FRAME_BYTES entries; a zero byte ends the frame. A data byte
// that closes a group with an implied zero passes through ST_ZERO too, as the
// store has a single write port. After the zero byte the controller reads the
// length and action bytes in ST_RD_LEN, ST_RD_ACT and ST_CAP_ACT, then each
// result through the single read port of the store in ST_RD_BODY and ST_LOAD,
// which waits while res stalls. The frame state is cleared as the last result
// is loaded, so the next frame may start while that result still waits on res.
module cobs_message_deframer
	import cobsd_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cobsd_rx_if.sink    rx,
	cobsd_res_if.source res
);

	dp_cmd_t    cmd;
	dp_status_t sts;

	cobsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cobsd_dp #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx.rx_byte),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (res.ready),
		.out_valid  (res.valid),
		.msg_length (res.msg_length),
		.msg_action (res.msg_action),
		.body_byte  (res.body_byte),
		.body_index (res.body_index),
		.body_valid (res.body_valid),
		.overflowed (res.overflowed),
		.last       (res.last)
	);

endmodule

// ----- test/cobs_message_deframer_tb.sv -----
module cobs_message_deframer_tb;
	import cobsd_pkg::*;

	localparam int STORE_BYTES = FRAME_BYTES_DEF;
	localparam int DIR_LEN = 25;
	localparam int DIR_FRAMES = 7;
	localparam int RANDOM_ITEMS = 355;

	typedef struct packed {
		logic [7:0] msg_len;
		logic [7:0] msg_act;
		logic [7:0] body;
		logic [5:0] index;
		logic       has_body;
		logic       ovf;
		logic       is_last;
	} deframed_t;

	logic clk = 1'b0;
	logic arst_n;

	cobsd_rx_if  rx_ch ();
	cobsd_res_if res_ch ();

	cobs_message_deframer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Frames of the directed part, each closed by a zero byte.
	logic [7:0] dir_bytes [0:DIR_LEN-1] = '{
		8'h00,
		8'h01, 8'h00,
		8'h03, 8'h02, 8'hFF, 8'h00,
		8'h03, 8'h01, 8'hAA, 8'h00,
		8'h05, 8'h06, 8'h11, 8'h22, 8'h33, 8'h00,
		8'h02, 8'hFF, 8'h01, 8'h00,
		8'hFF, 8'h07, 8'h7E, 8'h00
	};
	bit dir_typed [0:DIR_FRAMES-1] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
	deframed_t dir_expect [0:DIR_FRAMES-1] = '{
		'{8'h00, 8'h00, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1},
		'{8'h00, 8'h00, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1},
		'{8'h02, 8'hFF, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1},
		'{8'h01, 8'hAA, 8'h00, 6'd0, 1'b0, 1'b0, 1'b1},
		'{8'h00, 8'h00, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0},
		'{8'h00, 8'h00, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0},
		'{8'h00, 8'h00, 8'h00, 6'd0, 1'b0, 1'b0, 1'b0}
	};

	deframed_t due_results [$];
	logic [7:0] frame_plain [$];
	logic [7:0] frame_wire [$];

	logic [7:0]  frame_buf [0:STORE_BYTES-1];
	int unsigned buf_fill;
	logic [7:0]  bytes_to_go;
	bit          full_group;
	bit          dropped;

	bit          typed_pending;
	deframed_t   typed_result;

	int unsigned error_count;
	int unsigned sent_items;
	int unsigned hold_request;
	bit          idling_allowed;

	task automatic report_mismatch(input string what, input int unsigned want,
		input int unsigned got);
		$display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want, got);
		error_count++;
	endtask

	function automatic void keep_decoded(input logic [7:0] d);
		if (buf_fill < STORE_BYTES) begin
			frame_buf[buf_fill] = d;
			buf_fill++;
		end else begin
			dropped = 1'b1;
		end
	endfunction

	function automatic logic [7:0] decoded_at(input int unsigned pos);
		return (pos < buf_fill) ? frame_buf[pos] : 8'h00;
	endfunction

	// Decodes one received byte and queues the expected results that a frame end releases.
	function automatic void cobs_decode_byte(input logic [7:0] b);
		logic [7:0]  len_b;
		logic [7:0]  act_b;
		int unsigned n;
		bit          body_present;
		deframed_t   r;
		if (b != 8'h00) begin
			if (bytes_to_go == 8'd0) begin
				bytes_to_go = b - 8'd1;
				full_group = (b == GROUP_FULL_CODE);
			end else begin
				keep_decoded(b);
				bytes_to_go--;
			end
			if (bytes_to_go == 8'd0 && !full_group)
				keep_decoded(8'h00);
			return;
		end
		len_b = decoded_at(0);
		act_b = decoded_at(1);
		body_present = (len_b > 8'd2);
		n = body_present ? int'(len_b) - 2 : 1;
		if (n > STORE_BYTES - 2)
			n = STORE_BYTES - 2;
		for (int unsigned k = 0; k < n; k++) begin
			r.msg_len  = len_b;
			r.msg_act  = act_b;
			r.body     = body_present ? decoded_at(k + 2) : 8'h00;
			r.index    = body_present ? 6'(k) : 6'd0;
			r.has_body = body_present;
			r.ovf      = dropped;
			r.is_last  = (k + 1 == n);
			if (!typed_pending)
				due_results.push_back(r);
		end
		if (typed_pending) begin
			due_results.push_back(typed_result);
			typed_pending = 1'b0;
		end
		buf_fill = 0;
		bytes_to_go = 8'd0;
		full_group = 1'b0;
		dropped = 1'b0;
	endfunction

	function automatic void cobs_encode_plain();
		int unsigned code_at;
		logic [7:0]  run;
		frame_wire = {};
		code_at = 0;
		frame_wire.push_back(8'h00);
		run = 8'd1;
		foreach (frame_plain[i]) begin
			if (frame_plain[i] == 8'h00) begin
				frame_wire[code_at] = run;
				code_at = frame_wire.size();
				frame_wire.push_back(8'h00);
				run = 8'd1;
			end else begin
				frame_wire.push_back(frame_plain[i]);
				run++;
				if (run == GROUP_FULL_CODE) begin
					frame_wire[code_at] = run;
					code_at = frame_wire.size();
					frame_wire.push_back(8'h00);
					run = 8'd1;
				end
			end
		end
		frame_wire[code_at] = run;
		frame_wire.push_back(8'h00);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		if (idling_allowed && ((sent_items / 30) % 4 != 3) && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		sent_items++;
		cobs_decode_byte(b);
	endtask

	task automatic send_wire(input bit cut_short);
		int unsigned stop_at;
		stop_at = cut_short ? $urandom_range(1, frame_wire.size() - 2) : frame_wire.size();
		for (int unsigned i = 0; i < stop_at; i++)
			send_byte(frame_wire[i]);
		if (cut_short)
			send_byte(8'h00);
	endtask

	task automatic build_message(input int unsigned body_len, input bit honest_len);
		frame_plain = {};
		frame_plain.push_back(honest_len ? 8'(body_len + 2) : 8'($urandom_range(0, 255)));
		frame_plain.push_back(8'($urandom_range(0, 255)));
		repeat (body_len)
			frame_plain.push_back(($urandom_range(0, 5) == 0) ? 8'h00 :
				8'($urandom_range(1, 255)));
		cobs_encode_plain();
	endtask

	task automatic check_result();
		deframed_t got;
		deframed_t want;
		got = '{res_ch.msg_length, res_ch.msg_action, res_ch.body_byte, res_ch.body_index,
			res_ch.body_valid, res_ch.overflowed, res_ch.last};
		if (due_results.size() == 0) begin
			report_mismatch("unexpected result, body_byte", 0, got.body);
			return;
		end
		want = due_results.pop_front();
		if (got.msg_len !== want.msg_len)
			report_mismatch("msg_length", want.msg_len, got.msg_len);
		if (got.msg_act !== want.msg_act)
			report_mismatch("msg_action", want.msg_act, got.msg_act);
		if (got.body !== want.body)
			report_mismatch("body_byte", want.body, got.body);
		if (got.index !== want.index)
			report_mismatch("body_index", want.index, got.index);
		if (got.has_body !== want.has_body)
			report_mismatch("body_valid", want.has_body, got.has_body);
		if (got.ovf !== want.ovf)
			report_mismatch("overflowed", want.ovf, got.ovf);
		if (got.is_last !== want.is_last)
			report_mismatch("last", want.is_last, got.is_last);
	endtask

	initial begin
		int unsigned stall_left;
		int unsigned hold_left;
		int unsigned cyc;
		stall_left = 0;
		hold_left = 0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (res_ch.valid && res_ch.ready)
				check_result();
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (idling_allowed && ((cyc / 200) % 4 != 3) &&
				$urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned frame_no;
		int unsigned kind;
		bit          paused;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		res_ch.ready = 1'b0;
		error_count = 0;
		sent_items = 0;
		hold_request = 0;
		idling_allowed = 1'b1;
		typed_pending = 1'b0;
		buf_fill = 0;
		bytes_to_go = 8'd0;
		full_group = 1'b0;
		dropped = 1'b0;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		frame_no = 0;
		for (int i = 0; i < DIR_LEN; i++) begin
			if (dir_bytes[i] == 8'h00) begin
				typed_pending = dir_typed[frame_no];
				typed_result = dir_expect[frame_no];
				frame_no++;
			end
			send_byte(dir_bytes[i]);
		end

		// The receiver holds off while a frame whose length byte claims a long body is followed by more traffic.
		hold_request = 300;
		build_message(10, 1'b0);
		frame_plain[0] = 8'hFF;
		cobs_encode_plain();
		send_wire(1'b0);

		// One frame long enough to close a full group and overrun the store.
		frame_plain = {};
		repeat (258)
			frame_plain.push_back(8'($urandom_range(1, 255)));
		cobs_encode_plain();
		send_wire(1'b0);

		while (sent_items < DIR_LEN + RANDOM_ITEMS) begin
			if (sent_items >= DIR_LEN + RANDOM_ITEMS - 60)
				idling_allowed = 1'b0;
			if (!paused && sent_items > DIR_LEN + 150) begin
				paused = 1'b1;
				rx_ch.valid <= 1'b0;
				while (due_results.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				build_message($urandom_range(0, 12), 1'b1);
				send_wire(1'b0);
			end else if (kind == 4) begin
				build_message($urandom_range(0, 12), 1'b1);
				send_wire(1'b1);
			end else if (kind == 5) begin
				build_message($urandom_range(0, 12), 1'b0);
				send_wire(1'b0);
			end else if (kind == 6) begin
				build_message($urandom_range(13, 70), 1'b1);
				send_wire(1'b0);
			end else if (kind <= 8) begin
				repeat ($urandom_range(1, 10))
					send_byte(8'($urandom_range(0, 255)));
				send_byte(8'h00);
			end else begin
				send_byte(8'h00);
			end
		end

		rx_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("cobs_message_deframer test passed");
		else
			$display("cobs_message_deframer test failed");
		$finish;
	end

	initial begin
		#(12 * 5000000);
		$display("cobs_message_deframer test failed");
		$finish;
	end

endmodule
